@@ hdl/rkim_pkg.sv @@
// ----------------------------------------------------------------------------
// rkim_pkg: shared types and constants for the key-to-id map
// Table geometry, slot word layout, action, status and state codes.
// ----------------------------------------------------------------------------
package rkim_pkg;

  localparam int ENTRIES    = 64;
  localparam int COUNT_BITS = 16;

  localparam int KEY_W     = 32;
  localparam int ID_W      = 16;
  localparam int REFS_W    = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int OFF_W     = $clog2(ENTRIES + 1);
  localparam int CFG_IDX_W = 1;

  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [OFF_W-1:0]      LAST_OFF  = OFF_W'(ENTRIES);
  localparam logic [ID_W:0]         WIN_SPAN  = (ID_W + 1)'(ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ID = 1'b1;

  typedef enum logic [1:0] {
    ACT_GET  = 2'd0,
    ACT_PUT  = 2'd1,
    ACT_FIND = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SEARCH
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [ID_W-1:0]       ident;
    logic [COUNT_BITS-1:0] refs;
  } slot_t;

endpackage

@@ hdl/refcounted_key_to_id_map.sv @@
// ----------------------------------------------------------------------------
// refcounted_key_to_id_map: reference-counted key to identifier table
//
// Command port: a word (action_i, key_i, id_i) is taken at a rising edge with
// start high and busy low. busy stays high until the result is formed; the
// result (status_o, result_id_o, ref_count_o, found_key_o) is shown for one
// cycle with done_o high, and busy is already low in that cycle, so the next
// word can be taken at the edge that ends it. The receiver cannot stall.
// Get of key zero, put or find of identifier zero and the unused action code
// finish at once, with done_o raised in the cycle after acceptance.
// Every other word sweeps all ENTRIES slots of the slot RAM through its one
// read port, one slot a cycle, then decides in S_DECIDE and raises done_o.
// A get that must allocate then searches the identifier window from min_id,
// one candidate a cycle. Configuration (min_id at index 0, max_id at index
// 1) is written through cfg_we_i; the user must do so only while no word is
// in flight, which the block does not enforce. Reset clears all slot valid
// bits and loads min_id 1 and max_id 65535; no clearing pass is needed.
// ----------------------------------------------------------------------------
module refcounted_key_to_id_map (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      action_i,
  input  logic [rkim_pkg::KEY_W-1:0]      key_i,
  input  logic [rkim_pkg::ID_W-1:0]       id_i,
  input  logic                            cfg_we_i,
  input  logic [rkim_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rkim_pkg::ID_W-1:0]       cfg_wdata_i,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [rkim_pkg::ID_W-1:0]       result_id_o,
  output logic [rkim_pkg::REFS_W-1:0]     ref_count_o,
  output logic [rkim_pkg::KEY_W-1:0]      found_key_o
);

  import rkim_pkg::*;

  state_e                state_q, state_d;
  action_e               act_q, act_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [ID_W-1:0]       min_id_q, min_id_d;
  logic [ID_W-1:0]       max_id_q, max_id_d;
  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic                  issue_q, issue_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]      chk_idx_q, chk_idx_d;
  logic                  chk_last_q, chk_last_d;
  logic                  hit_q, hit_d;
  logic [IDX_W-1:0]      hit_idx_q, hit_idx_d;
  slot_t                 hit_word_q, hit_word_d;
  logic                  free_q, free_d;
  logic [IDX_W-1:0]      free_idx_q, free_idx_d;
  logic [ENTRIES:0]      used_map_q, used_map_d;
  logic [OFF_W-1:0]      off_q, off_d;
  logic                  done_q, done_d;
  status_e               status_q, status_d;
  logic [ID_W-1:0]       rid_q, rid_d;
  logic [COUNT_BITS-1:0] refs_q, refs_d;
  logic [KEY_W-1:0]      fkey_q, fkey_d;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  slot_t                 ram_wdata;
  logic                  ram_re;
  slot_t                 rd_word;

  logic [ID_W:0]         win_diff;
  logic                  in_win;
  logic                  slot_match;
  logic [COUNT_BITS-1:0] refs_inc;
  logic [COUNT_BITS-1:0] refs_dec;
  logic [ID_W:0]         cand;

  rkim_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_word)
  );

  assign ram_re     = (state_q == S_SCAN) && issue_q;
  assign win_diff   = {1'b0, rd_word.ident} - {1'b0, min_id_q};
  assign in_win     = !win_diff[ID_W] && (win_diff <= WIN_SPAN);
  assign slot_match = (act_q == ACT_GET) ? (rd_word.key == key_q) : (rd_word.ident == id_q);
  assign refs_inc   = (hit_word_q.refs == COUNT_MAX) ? hit_word_q.refs : hit_word_q.refs + 1'b1;
  assign refs_dec   = hit_word_q.refs - 1'b1;
  assign cand       = {1'b0, min_id_q} + (ID_W + 1)'(off_q);

  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    key_d      = key_q;
    id_d       = id_q;
    min_id_d   = min_id_q;
    max_id_d   = max_id_q;
    valid_d    = valid_q;
    rd_idx_d   = rd_idx_q;
    issue_d    = issue_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = rd_idx_q;
    chk_last_d = 1'b0;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_word_d = hit_word_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    used_map_d = used_map_q;
    off_d      = off_q;
    done_d     = 1'b0;
    status_d   = status_q;
    rid_d      = rid_q;
    refs_d     = refs_q;
    fkey_d     = fkey_q;
    ram_we     = 1'b0;
    ram_waddr  = hit_idx_q;
    ram_wdata  = hit_word_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_ID: min_id_d = cfg_wdata_i;
        CFG_MAX_ID: max_id_d = cfg_wdata_i;
        default:    min_id_d = min_id_q;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          act_d      = action_e'(action_i);
          key_d      = key_i;
          id_d       = id_i;
          hit_d      = 1'b0;
          free_d     = 1'b0;
          used_map_d = '0;
          rd_idx_d   = '0;
          issue_d    = 1'b1;
          state_d    = S_SCAN;
          status_d   = STAT_OK;
          rid_d      = '0;
          refs_d     = '0;
          fkey_d     = '0;
          unique case (action_e'(action_i))
            ACT_GET: begin
              if (key_i == '0) begin
                done_d = 1'b1;
              end
            end
            ACT_PUT: begin
              if (id_i == '0) begin
                done_d = 1'b1;
              end
            end
            ACT_FIND: begin
              if (id_i == '0) begin
                done_d   = 1'b1;
                status_d = STAT_NOT_FOUND;
              end
            end
            ACT_NONE: begin
              done_d = 1'b1;
            end
          endcase
          if (done_d) begin
            state_d = S_IDLE;
            issue_d = 1'b0;
          end
        end
      end

      S_SCAN: begin
        chk_vld_d  = issue_q;
        chk_last_d = issue_q && (rd_idx_q == LAST_IDX);
        if (issue_q) begin
          if (rd_idx_q == LAST_IDX) begin
            issue_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        if (chk_vld_q) begin
          if (valid_q[chk_idx_q]) begin
            if (slot_match) begin
              hit_d      = 1'b1;
              hit_idx_d  = chk_idx_q;
              hit_word_d = rd_word;
            end
            if (in_win) begin
              used_map_d[win_diff[OFF_W-1:0]] = 1'b1;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = chk_idx_q;
          end
          if (chk_last_q) begin
            state_d = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        unique case (act_q)
          ACT_GET: begin
            if (hit_q) begin
              ram_we         = 1'b1;
              ram_wdata.refs = refs_inc;
              rid_d          = hit_word_q.ident;
              refs_d         = refs_inc;
            end else if (!free_q) begin
              status_d = STAT_FULL;
            end else begin
              done_d  = 1'b0;
              off_d   = '0;
              state_d = S_SEARCH;
            end
          end
          ACT_PUT: begin
            rid_d = id_q;
            if (hit_q) begin
              ram_we         = 1'b1;
              ram_wdata.refs = refs_dec;
              refs_d         = refs_dec;
              if (refs_dec == '0) begin
                valid_d[hit_idx_q] = 1'b0;
              end
            end else begin
              status_d = STAT_NOT_FOUND;
            end
          end
          ACT_FIND: begin
            rid_d = id_q;
            if (hit_q) begin
              refs_d = hit_word_q.refs;
              fkey_d = hit_word_q.key;
            end else begin
              status_d = STAT_NOT_FOUND;
            end
          end
          ACT_NONE: begin
            status_d = STAT_OK;
          end
        endcase
      end

      S_SEARCH: begin
        if (cand > {1'b0, max_id_q}) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = STAT_FULL;
        end else if ((cand[ID_W-1:0] != '0) && !used_map_q[off_q]) begin
          ram_we             = 1'b1;
          ram_waddr          = free_idx_q;
          ram_wdata.key      = key_q;
          ram_wdata.ident    = cand[ID_W-1:0];
          ram_wdata.refs     = COUNT_ONE;
          valid_d[free_idx_q] = 1'b1;
          rid_d              = cand[ID_W-1:0];
          refs_d             = COUNT_ONE;
          state_d            = S_IDLE;
          done_d             = 1'b1;
        end else if (off_q == LAST_OFF) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = STAT_FULL;
        end else begin
          off_d = off_q + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      min_id_q   <= ID_W'(1);
      max_id_q   <= {ID_W{1'b1}};
      valid_q    <= '0;
      issue_q    <= 1'b0;
      chk_vld_q  <= 1'b0;
      chk_last_q <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      used_map_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      min_id_q   <= min_id_d;
      max_id_q   <= max_id_d;
      valid_q    <= valid_d;
      issue_q    <= issue_d;
      chk_vld_q  <= chk_vld_d;
      chk_last_q <= chk_last_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
      used_map_q <= used_map_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    key_q      <= key_d;
    id_q       <= id_d;
    rd_idx_q   <= rd_idx_d;
    chk_idx_q  <= chk_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_word_q <= hit_word_d;
    free_idx_q <= free_idx_d;
    off_q      <= off_d;
    status_q   <= status_d;
    rid_q      <= rid_d;
    refs_q     <= refs_d;
    fkey_q     <= fkey_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign result_id_o = rid_q;
  assign ref_count_o = REFS_W'(refs_q);
  assign found_key_o = fkey_q;

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted word neither in flight nor finished");

  a_check_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> (state_q == S_SCAN))
    else $error("slot read returned outside the sweep");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_FULL)) |-> ((result_id_o == '0) && (ref_count_o == '0)))
    else $error("full result carries an identifier");
`endif

endmodule

@@ hdl/rkim_ram.sv @@
// ----------------------------------------------------------------------------
// rkim_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rkim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
